// File: design/i2cms_pkg.sv
package i2cms_pkg;

	// width of the phase hold counter
	localparam int DLY_W = 8;
	localparam int CFG_W = 8;
	localparam logic [DLY_W-1:0] CNT_MAX = '1;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_SEND  = 3'd3,
		CMD_RECV  = 3'd4,
		CMD_ACK   = 3'd5,
		CMD_NACK  = 3'd6,
		CMD_WAIT  = 3'd7
	} cmd_t;

	typedef logic [2:0] phase_t;
	localparam phase_t PH0 = 3'd0;
	localparam phase_t PH1 = 3'd1;
	localparam phase_t PH2 = 3'd2;
	localparam phase_t PH3 = 3'd3;
	localparam phase_t PH4 = 3'd4;

	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] half_period_ticks;
		logic [CFG_W-1:0] ack_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		cmd_t       req_type;
		logic [7:0] tx_byte;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_error;
		logic       rejected;
	} res_t;

	// zero acts as one, anything above the counter range is clipped
	function automatic logic [DLY_W-1:0] limit(input logic [CFG_W-1:0] r);
		logic [CFG_W-1:0] v;
		v = (r == '0) ? CFG_W'(1) : r;
		if (int'(v) > int'(CNT_MAX))
			return CNT_MAX;
		return DLY_W'(v);
	endfunction

endpackage

// File: design/i2cms_seq.sv
module i2cms_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cms_pkg::req_t req,
	input  i2cms_pkg::cfg_t cfg,
	output i2cms_pkg::res_t res
);

	i2cms_pkg::cmd_t                  cmd_q, n_cmd;
	i2cms_pkg::phase_t                phase_q, n_phase, enter_p;
	logic [i2cms_pkg::DLY_W-1:0]      tick_q, n_tick, lim_hp, lim_to;
	logic [3:0]                       bit_q, n_bit;
	logic [7:0]                       tx_q, n_tx, rx_q, n_rx;
	logic                             ack_q, n_ack;
	logic                             scl_q, n_scl, sda_q, n_sda, oe_q, n_oe;
	logic                             done, rej, enter_en;

	assign lim_hp = i2cms_pkg::limit(cfg.half_period_ticks);
	assign lim_to = i2cms_pkg::limit(cfg.ack_timeout_ticks);

	always_comb begin
		n_cmd    = cmd_q;
		n_phase  = phase_q;
		n_tick   = tick_q;
		n_bit    = bit_q;
		n_tx     = tx_q;
		n_rx     = rx_q;
		n_ack    = ack_q;
		n_scl    = scl_q;
		n_sda    = sda_q;
		n_oe     = oe_q;
		done     = 1'b0;
		rej      = 1'b0;
		enter_en = 1'b0;
		enter_p  = i2cms_pkg::PH0;

		if (step) begin
			if (req.req_type != i2cms_pkg::CMD_IDLE) begin
				if (cmd_q != i2cms_pkg::CMD_IDLE) begin
					rej = 1'b1;
				end else begin
					n_cmd = req.req_type;
					n_bit = '0;
					if (req.req_type == i2cms_pkg::CMD_SEND) begin
						n_tx = req.tx_byte;
						n_oe = 1'b1;
					end
					if (req.req_type == i2cms_pkg::CMD_RECV) begin
						n_rx  = '0;
						n_oe  = 1'b0;
						n_sda = 1'b1;
					end
					enter_en = 1'b1;
				end
			end else if (cmd_q != i2cms_pkg::CMD_IDLE) begin
				if (tick_q < i2cms_pkg::CNT_MAX)
					n_tick = tick_q + 1'b1;
				if (cmd_q == i2cms_pkg::CMD_WAIT && phase_q == i2cms_pkg::PH3) begin
					// SDA low wins over the timeout
					if (!req.sda_in) begin
						n_ack    = 1'b0;
						enter_en = 1'b1;
						enter_p  = i2cms_pkg::PH4;
					end else if (n_tick >= lim_to) begin
						n_ack    = 1'b1;
						enter_en = 1'b1;
						enter_p  = i2cms_pkg::PH4;
					end
				end else if (n_tick >= lim_hp) begin
					unique case (cmd_q)
						i2cms_pkg::CMD_START: begin
							if (phase_q < i2cms_pkg::PH2) begin
								enter_en = 1'b1;
								enter_p  = phase_q + 1'b1;
							end else begin
								done = 1'b1;
							end
						end
						i2cms_pkg::CMD_STOP, i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
							if (phase_q < i2cms_pkg::PH3) begin
								enter_en = 1'b1;
								enter_p  = phase_q + 1'b1;
							end else begin
								done = 1'b1;
							end
						end
						i2cms_pkg::CMD_SEND: begin
							if (phase_q < i2cms_pkg::PH2) begin
								enter_en = 1'b1;
								enter_p  = phase_q + 1'b1;
							end else begin
								n_bit = bit_q + 1'b1;
								if (n_bit >= i2cms_pkg::BITS_PER_BYTE) begin
									n_scl = 1'b0;
									done  = 1'b1;
								end else begin
									enter_en = 1'b1;
								end
							end
						end
						i2cms_pkg::CMD_RECV: begin
							if (phase_q == i2cms_pkg::PH0) begin
								enter_en = 1'b1;
								enter_p  = i2cms_pkg::PH1;
							end else begin
								n_rx  = rx_q | {7'd0, req.sda_in};
								n_bit = bit_q + 1'b1;
								if (n_bit >= i2cms_pkg::BITS_PER_BYTE) begin
									n_scl = 1'b0;
									done  = 1'b1;
								end else begin
									enter_en = 1'b1;
								end
							end
						end
						default: begin
							// wait-ack: first poll on the tick that ends the SCL high hold
							if (phase_q < i2cms_pkg::PH2) begin
								enter_en = 1'b1;
								enter_p  = phase_q + 1'b1;
							end else if (phase_q == i2cms_pkg::PH2) begin
								enter_en = 1'b1;
								enter_p  = i2cms_pkg::PH3;
								if (!req.sda_in) begin
									n_ack   = 1'b0;
									enter_p = i2cms_pkg::PH4;
								end
							end else begin
								done = 1'b1;
							end
						end
					endcase
				end
			end
		end

		if (done) begin
			n_cmd   = i2cms_pkg::CMD_IDLE;
			n_phase = i2cms_pkg::PH0;
			n_tick  = '0;
		end

		// line changes happen on the item that enters a phase; SEND and RECV also drop SCL on the item that completes them
		if (enter_en) begin
			n_phase = enter_p;
			n_tick  = '0;
			unique case (n_cmd)
				i2cms_pkg::CMD_START: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_oe  = 1'b1;
						n_sda = 1'b1;
						n_scl = 1'b1;
					end else if (enter_p == i2cms_pkg::PH1) begin
						n_sda = 1'b0;
					end else begin
						n_scl = 1'b0;
					end
				end
				i2cms_pkg::CMD_STOP: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_oe  = 1'b1;
						n_scl = 1'b0;
					end else if (enter_p == i2cms_pkg::PH1) begin
						n_sda = 1'b0;
					end else if (enter_p == i2cms_pkg::PH2) begin
						n_scl = 1'b1;
					end else begin
						n_sda = 1'b1;
					end
				end
				i2cms_pkg::CMD_ACK, i2cms_pkg::CMD_NACK: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_oe  = 1'b1;
						n_scl = 1'b0;
					end else if (enter_p == i2cms_pkg::PH1) begin
						n_sda = (n_cmd == i2cms_pkg::CMD_NACK);
					end else if (enter_p == i2cms_pkg::PH2) begin
						n_scl = 1'b1;
					end else begin
						n_scl = 1'b0;
					end
				end
				i2cms_pkg::CMD_SEND: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_scl = 1'b0;
					end else if (enter_p == i2cms_pkg::PH1) begin
						n_sda = n_tx[7];
						n_tx  = {n_tx[6:0], 1'b0};
					end else begin
						n_scl = 1'b1;
					end
				end
				i2cms_pkg::CMD_RECV: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_rx  = {n_rx[6:0], 1'b0};
						n_scl = 1'b0;
					end else begin
						n_scl = 1'b1;
					end
				end
				i2cms_pkg::CMD_WAIT: begin
					if (enter_p == i2cms_pkg::PH0) begin
						n_oe  = 1'b0;
						n_scl = 1'b0;
					end else if (enter_p == i2cms_pkg::PH1) begin
						n_sda = 1'b1;
					end else if (enter_p == i2cms_pkg::PH2) begin
						n_scl = 1'b1;
					end else if (enter_p == i2cms_pkg::PH4) begin
						n_scl = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.scl_level = n_scl;
		res.sda_level = n_sda;
		res.sda_drive = n_oe;
		res.busy_res  = (n_cmd != i2cms_pkg::CMD_IDLE);
		res.done_res  = done;
		res.rx_byte   = (done && cmd_q == i2cms_pkg::CMD_RECV) ? n_rx : 8'd0;
		res.ack_error = n_ack;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cms_pkg::CMD_IDLE;
			phase_q <= i2cms_pkg::PH0;
			tick_q  <= '0;
			bit_q   <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			oe_q    <= 1'b1;
		end else if (step) begin
			cmd_q   <= n_cmd;
			phase_q <= n_phase;
			tick_q  <= n_tick;
			bit_q   <= n_bit;
			tx_q    <= n_tx;
			rx_q    <= n_rx;
			ack_q   <= n_ack;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			oe_q    <= n_oe;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.busy_res)
		else $error("command completed but sequencer still busy");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.rejected |=> $stable(cmd_q) && $stable(phase_q) && $stable(tick_q))
		else $error("rejected command changed sequencer state");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q == i2cms_pkg::CMD_IDLE |-> phase_q == i2cms_pkg::PH0 && tick_q == '0)
		else $error("idle with phase or tick count left over");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= i2cms_pkg::BITS_PER_BYTE)
		else $error("bit count ran past one byte");

endmodule

// File: design/i2cms_obuf.sv
module i2cms_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cms_pkg::res_t push_data,
	output logic            push_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output i2cms_pkg::res_t out_data
);

	logic            main_valid_q, spare_valid_q;
	i2cms_pkg::res_t main_q, spare_q;
	logic            pop;

	assign push_ready = !spare_valid_q;
	assign out_valid  = main_valid_q;
	assign out_data   = main_q;
	assign pop        = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q  <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (pop) begin
				if (spare_valid_q) begin
					spare_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				spare_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= spare_valid_q ? spare_q : push_data;
		end
		if (main_valid_q && !pop && push) begin
			spare_q <= push_data;
		end
	end

	a_spare_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> main_valid_q)
		else $error("spare slot full while output slot empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q && !pop |=> spare_valid_q && $stable(spare_q))
		else $error("spare slot lost an item");

	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q && pop |=> main_valid_q && main_q == $past(spare_q))
		else $error("spare item not moved to output slot");

endmodule

// File: design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer.
// Input stream s_axis carries one item per tick or command. The sequencer
// steps SCL/SDA phases on tick items and takes one command while idle; a
// command that arrives while busy comes back with rejected set.
// Every input item produces exactly one result item on m_axis with the line
// levels and status after that item.
// Configuration: cfg_we / cfg_index / cfg_wdata, index 0 half period in
// ticks, index 1 ack timeout in ticks; write only while idle.
// Path: an accepted input item waits in the input register, then the
// next-state logic feeds the output register, where the result becomes valid.
// Throughput: one item per cycle while the output buffer's spare slot is
// free; the state update is a loop from the sequencer's registered state.
// A two-entry output buffer lets the block keep taking items after
// m_axis_tready drops until the spare slot fills; then s_axis_tready goes
// low until the receiver takes an item, and no item is dropped.
// Reset: both config registers return to 4, the sequencer goes idle with
// SCL and SDA high and SDA driven; all buffered items are discarded.
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] req_type, [10:3] tx_byte, [11] sda_in
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] rx_byte, [13] ack_error, [14] rejected
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic            in_valid_s1;
	logic [11:0]     in_data_s1;
	logic            buf_ready, step;
	i2cms_pkg::req_t req;
	i2cms_pkg::res_t res, out_res;
	i2cms_pkg::cfg_t cfg_q;

	assign step          = in_valid_s1 && buf_ready;
	assign s_axis_tready = !in_valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_data_s1 <= s_axis_tdata[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= 8'd4;
			cfg_q.ack_timeout_ticks <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cms_pkg::CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata;
				i2cms_pkg::CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		req.req_type = i2cms_pkg::cmd_t'(in_data_s1[2:0]);
		req.tx_byte  = in_data_s1[10:3];
		req.sda_in   = in_data_s1[11];
	end

	i2cms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req),
		.cfg    (cfg_q),
		.res    (res)
	);

	i2cms_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (res),
		.push_ready (buf_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (out_res)
	);

	assign m_axis_tdata = {1'b0, out_res.rejected, out_res.ack_error, out_res.rx_byte,
		out_res.done_res, out_res.busy_res, out_res.sda_drive, out_res.sda_level,
		out_res.scl_level};

endmodule
